// ----- src/ina_pkg.sv -----
// shared types and constants for the intra neighbour availability block
// used by ina_decide and intra_neighbour_availability; no dependencies
package ina_pkg;

   localparam int unsigned REQ_DATA_W = 112;
   localparam int unsigned RSP_DATA_W = 24;
   localparam int unsigned CSR_DATA_W = 14;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned FLAGS_W = 17;
   localparam int unsigned COUNT_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PICTURE_WIDTH  = 2'd0,
      CSR_PICTURE_HEIGHT = 2'd1,
      CSR_TREE_UNIT_WIDTH = 2'd2
   } csr_index_type;

   localparam logic [1:0] SIZE_64 = 2'd3;

   typedef struct packed {
      logic [63:0] done_map;
      logic        top_right_tree_ok;
      logic        top_left_tree_ok;
      logic        top_tree_ok;
      logic        left_tree_ok;
      logic [12:0] picture_y;
      logic [12:0] picture_x;
      logic [1:0]  size_code;
      logic [5:0]  unit_y;
      logic [5:0]  unit_x;
   } item_type;

   typedef struct packed {
      logic [13:0] picture_width;
      logic [13:0] picture_height;
      logic [6:0]  tree_unit_width;
   } cfg_type;

   typedef struct packed {
      logic               skipped;
      logic [COUNT_W-1:0] region_count;
      logic [FLAGS_W-1:0] neighbour_flags;
   } result_type;

endpackage

// ----- src/intra_neighbour_availability.sv -----
// top level: stream ports, configuration registers and the two-stage pipeline
// depends on ina_pkg and ina_decide
//
// Intra neighbour availability: takes one coding unit per beat and returns one
// result beat telling which of the bottom-left, left, top-left, top and
// top-right reference regions are usable, one flag per 8 pixels, plus the count
// of usable regions. A beat is registered on input, decided in combinational
// logic and registered on output; a new beat is taken every cycle as long as the
// result side keeps up, and the output stage, and a full input stage, hold while
// a result beat waits with rsp_tready low. Configuration writes are taken at any
// edge with csr_we high and should only happen while no beat is in flight.
module intra_neighbour_availability
   import ina_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // unit_x, unit_y, size_code, picture_x, picture_y, left_tree_ok,
   // top_tree_ok, top_left_tree_ok, top_right_tree_ok, done_map, zero pad
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // neighbour_flags, region_count, zero pad
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // skipped
   output logic                   rsp_tuser,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type    cfg_ff;
   item_type   item_ff;
   logic       item_valid_ff;
   result_type result;
   result_type result_ff;
   logic       rsp_valid_ff;
   logic       out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.picture_width <= 14'd1920;
         cfg_ff.picture_height <= 14'd1080;
         cfg_ff.tree_unit_width <= 7'd64;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PICTURE_WIDTH:   cfg_ff.picture_width <= csr_wdata;
            CSR_PICTURE_HEIGHT:  cfg_ff.picture_height <= csr_wdata;
            CSR_TREE_UNIT_WIDTH: cfg_ff.tree_unit_width <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   assign out_ready = !rsp_valid_ff || rsp_tready;
   assign req_tready = !item_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_type'(req_tdata[$bits(item_type)-1:0]);
      end
   end

   ina_decide u_decide (
      .item   (item_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && item_valid_ff) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {{(RSP_DATA_W - FLAGS_W - COUNT_W){1'b0}},
                       result_ff.region_count, result_ff.neighbour_flags};
   assign rsp_tuser = result_ff.skipped;

   // a held input beat moves to the output whenever the output can take it
   a_advance: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && out_ready |=> rsp_tvalid)
      else $error("input stage beat did not reach the output stage");

   // a skipped unit carries no flags and no count
   a_skip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("skipped result with nonzero flags or count");

   // no flags means no regions counted
   a_count_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[FLAGS_W-1:0] == '0) ==
                      (rsp_tdata[FLAGS_W+COUNT_W-1:FLAGS_W] == '0)))
      else $error("region count disagrees with flags");

   // pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid && !item_valid_ff)
      else $error("pipeline not empty after reset");

endmodule

// ----- src/ina_decide.sv -----
// availability decision for one coding unit, purely combinational
// depends on ina_pkg
module ina_decide
   import ina_pkg::*;
(
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   logic [7:0]  unit_size;
   logic [7:0]  x_end;
   logic [7:0]  y_end;
   logic [13:0] px_end;
   logic [13:0] py_end;
   logic [4:0]  n;
   logic [FLAGS_W-1:0] mask;
   logic        left, top, tl_avail, bl_avail, tr_avail, cand_tr;
   logic        bl_done, tr_done;
   logic [2:0]  bl_col, tr_row;
   logic [5:0]  bl_bit, tr_bit;

   always_comb begin
      unit_size = 8'd8 << item.size_code;
      n = 5'd1 << item.size_code;
      x_end = {2'b00, item.unit_x} + unit_size;
      y_end = {2'b00, item.unit_y} + unit_size;
      px_end = {1'b0, item.picture_x} + {6'd0, unit_size};
      py_end = {1'b0, item.picture_y} + {6'd0, unit_size};

      // map lookups; rows or columns off the map read as not coded
      bl_col = item.unit_x[5:3] - 3'd1;
      bl_bit = {y_end[5:3], bl_col};
      bl_done = (item.unit_x == 6'd0) ||
                ((item.unit_x[5:3] != 3'd0) && (y_end[7:6] == 2'b00) &&
                 item.done_map[bl_bit]);
      tr_row = item.unit_y[5:3] - 3'd1;
      tr_bit = {tr_row, x_end[5:3]};
      tr_done = (item.unit_y == 6'd0) ||
                ((item.unit_y[5:3] != 3'd0) && (x_end[7:6] == 2'b00) &&
                 item.done_map[tr_bit]);

      left = item.left_tree_ok || (item.unit_x != 6'd0);
      top = item.top_tree_ok || (item.unit_y != 6'd0);
      tl_avail = left && top &&
                 (item.top_left_tree_ok || (item.unit_x != 6'd0) || (item.unit_y != 6'd0));

      if (x_end == {1'b0, cfg.tree_unit_width}) begin
         cand_tr = item.top_right_tree_ok && (item.unit_y == 6'd0) &&
                   (item.picture_y != 13'd0);
      end else begin
         cand_tr = top;
      end

      bl_avail = left && (y_end != {1'b0, cfg.tree_unit_width}) &&
                 (py_end < cfg.picture_height) && bl_done;
      tr_avail = cand_tr && (px_end < cfg.picture_width) && tr_done;

      mask = (FLAGS_W'(1) << n) - FLAGS_W'(1);

      if (item.size_code == SIZE_64) begin
         result.skipped = 1'b1;
         result.region_count = '0;
         result.neighbour_flags = '0;
      end else begin
         result.skipped = 1'b0;
         result.region_count = COUNT_W'(bl_avail) + COUNT_W'(left) +
                               COUNT_W'(tl_avail) + COUNT_W'(top) + COUNT_W'(tr_avail);
         result.neighbour_flags = (bl_avail ? mask : '0)
                                | (left ? (mask << n) : '0)
                                | (tl_avail ? (FLAGS_W'(1) << 8) : '0)
                                | (top ? (mask << 9) : '0)
                                | (tr_avail ? (mask << (5'd9 + n)) : '0);
      end
   end

endmodule

// ----- dv/tb.sv -----
// testbench for intra_neighbour_availability: directed and random coding units
// checked against a scoreboard that predicts the neighbour flags and region count
// depends on ina_pkg and the block's rtl only
import ina_pkg::*;

class availability_scoreboard;
   int unsigned picture_width;
   int unsigned picture_height;
   int unsigned tree_unit_width;
   int unsigned errors;
   result_type pending_results[$];

   function new();
      picture_width = 1920;
      picture_height = 1080;
      tree_unit_width = 64;
      errors = 0;
   endfunction

   function void set_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_PICTURE_WIDTH: picture_width = value;
         CSR_PICTURE_HEIGHT: picture_height = value;
         CSR_TREE_UNIT_WIDTH: tree_unit_width = value[6:0];
         default: ;
      endcase
   endfunction

   // off-map lookups read as not coded
   function bit block_coded(logic [63:0] map, int row, int col);
      if (row < 0 || row > 7 || col < 0 || col > 7)
         return 1'b0;
      return map[row*8 + col];
   endfunction

   function result_type predict_availability(item_type u);
      result_type r;
      int ux, uy, px, py, s, n, count;
      bit left, top, tl_avail, bl_avail, tr_avail, tr_cand, bl_done, tr_done;
      logic [FLAGS_W-1:0] flags;
      r = '0;
      if (u.size_code == SIZE_64) begin
         r.skipped = 1'b1;
         return r;
      end
      ux = int'(u.unit_x);
      uy = int'(u.unit_y);
      px = int'(u.picture_x);
      py = int'(u.picture_y);
      s = 8 << u.size_code;
      n = s / 8;
      bl_done = (ux == 0) || block_coded(u.done_map, (uy + s) / 8, ux / 8 - 1);
      tr_done = (uy == 0) || block_coded(u.done_map, uy / 8 - 1, (ux + s) / 8);
      left = u.left_tree_ok || ux != 0;
      top = u.top_tree_ok || uy != 0;
      tl_avail = left && top && (u.top_left_tree_ok || ux != 0 || uy != 0);
      if (ux + s == int'(tree_unit_width))
         tr_cand = u.top_right_tree_ok && uy == 0 && py != 0;
      else
         tr_cand = top;
      bl_avail = left && (uy + s != int'(tree_unit_width)) &&
                 (py + s < int'(picture_height)) && bl_done;
      tr_avail = tr_cand && (px + s < int'(picture_width)) && tr_done;
      flags = '0;
      count = 0;
      if (bl_avail) begin flags |= FLAGS_W'((1 << n) - 1); count++; end
      if (left) begin flags |= FLAGS_W'(((1 << n) - 1) << n); count++; end
      if (tl_avail) begin flags |= FLAGS_W'(1 << 8); count++; end
      if (top) begin flags |= FLAGS_W'(((1 << n) - 1) << 9); count++; end
      if (tr_avail) begin flags |= FLAGS_W'(((1 << n) - 1) << (9 + n)); count++; end
      r.neighbour_flags = flags;
      r.region_count = COUNT_W'(count);
      return r;
   endfunction

   function void note_unit(item_type u);
      pending_results.push_back(predict_availability(u));
   endfunction

   function void check_beat(result_type got);
      result_type want;
      if (pending_results.size() == 0) begin
         $error("unexpected result beat: flags %h count %0d skipped %0d",
                got.neighbour_flags, got.region_count, got.skipped);
         errors++;
         return;
      end
      want = pending_results.pop_front();
      if (got.neighbour_flags !== want.neighbour_flags) begin
         $error("neighbour_flags: expected %h, got %h", want.neighbour_flags,
                got.neighbour_flags);
         errors++;
      end
      if (got.region_count !== want.region_count) begin
         $error("region_count: expected %0d, got %0d", want.region_count,
                got.region_count);
         errors++;
      end
      if (got.skipped !== want.skipped) begin
         $error("skipped: expected %0d, got %0d", want.skipped, got.skipped);
         errors++;
      end
   endfunction
endclass

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int ITEM_W = $bits(item_type);

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int unsigned sender_idle_pct;
   int unsigned receiver_stall_pct;
   availability_scoreboard sb;

   intra_neighbour_availability dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // sampled at the edge, before any update of this step lands
   always @(posedge clock) begin
      result_type got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.neighbour_flags = rsp_tdata[FLAGS_W-1:0];
            got.region_count = rsp_tdata[FLAGS_W +: COUNT_W];
            got.skipped = rsp_tuser;
            sb.check_beat(got);
         end
         if (req_tvalid && req_tready)
            sb.note_unit(item_type'(req_tdata[ITEM_W-1:0]));
      end
   end

   function automatic item_type make_unit(int ux, int uy, int sc, int px, int py,
                                          logic [3:0] tree_ok, logic [63:0] map);
      item_type u;
      u.unit_x = 6'(ux);
      u.unit_y = 6'(uy);
      u.size_code = 2'(sc);
      u.picture_x = 13'(px);
      u.picture_y = 13'(py);
      // tree_ok from the top down: top-right, top-left, top, left
      {u.top_right_tree_ok, u.top_left_tree_ok, u.top_tree_ok, u.left_tree_ok} = tree_ok;
      u.done_map = map;
      return u;
   endfunction

   task automatic send_unit(item_type u);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_DATA_W'(u);
      do @(posedge clock); while (!req_tready);
   endtask

   // hold the sender until every result is back, then let the pipe empty
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do
         @(posedge clock);
      while (sb.pending_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_settings(int unsigned width, int unsigned height, int unsigned ctu);
      logic [CSR_DATA_W-1:0] junk;
      junk = CSR_DATA_W'($urandom_range(16383));
      csr_we <= 1'b1;
      csr_index <= CSR_PICTURE_WIDTH;
      csr_wdata <= CSR_DATA_W'(width);
      sb.set_reg(CSR_PICTURE_WIDTH, CSR_DATA_W'(width));
      @(posedge clock);
      csr_index <= CSR_PICTURE_HEIGHT;
      csr_wdata <= CSR_DATA_W'(height);
      sb.set_reg(CSR_PICTURE_HEIGHT, CSR_DATA_W'(height));
      @(posedge clock);
      csr_index <= CSR_TREE_UNIT_WIDTH;
      csr_wdata <= CSR_DATA_W'(ctu);
      sb.set_reg(CSR_TREE_UNIT_WIDTH, CSR_DATA_W'(ctu));
      @(posedge clock);
      // index past the register list must be ignored
      csr_index <= CSR_UNUSED;
      csr_wdata <= junk;
      sb.set_reg(CSR_UNUSED, junk);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_random_phase(int items);
      item_type u;
      int s, span, v;
      for (int i = 0; i < items; i++) begin
         u = item_type'({$urandom, $urandom, $urandom, $urandom});
         if ($urandom_range(99) < 80) begin
            // aligned unit inside the tree unit, positions often near the picture edges
            u.size_code = ($urandom_range(9) == 0) ? SIZE_64 : 2'($urandom_range(2));
            s = 8 << u.size_code;
            span = int'(sb.tree_unit_width) / s;
            if (span < 1)
               span = 1;
            u.unit_x = 6'($urandom_range(span - 1) * s);
            u.unit_y = 6'($urandom_range(span - 1) * s);
            if ($urandom_range(3) == 0)
               v = int'(sb.picture_width) - s - 1 + $urandom_range(2);
            else
               v = $urandom_range(sb.picture_width - 1);
            u.picture_x = 13'((v < 0) ? 0 : (v > 8191) ? 8191 : v);
            case ($urandom_range(7))
               0: v = 0;
               1, 2: v = int'(sb.picture_height) - s - 1 + $urandom_range(2);
               default: v = $urandom_range(sb.picture_height - 1);
            endcase
            u.picture_y = 13'((v < 0) ? 0 : (v > 8191) ? 8191 : v);
            u.left_tree_ok = ($urandom_range(3) != 0);
            u.top_tree_ok = ($urandom_range(3) != 0);
            u.top_left_tree_ok = ($urandom_range(3) != 0);
            u.top_right_tree_ok = ($urandom_range(3) != 0);
            if ($urandom_range(3) == 0)
               u.done_map = '1;
         end
         send_unit(u);
      end
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_PICTURE_WIDTH;
      csr_wdata = '0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed units under the reset settings
      send_unit(make_unit(0, 0, 0, 0, 0, 4'b0000, 64'h0));
      send_unit(make_unit(0, 0, 0, 0, 0, 4'b1111, '1));
      send_unit(make_unit(0, 0, 3, 0, 0, 4'b1111, '1));
      send_unit(make_unit(63, 63, 0, 8191, 8191, 4'b0000, '1));
      send_unit(make_unit(56, 0, 0, 100, 0, 4'b1111, '1));
      send_unit(make_unit(56, 0, 0, 100, 8, 4'b1111, '1));
      send_unit(make_unit(56, 0, 0, 100, 8, 4'b0111, '1));
      send_unit(make_unit(48, 0, 1, 100, 8, 4'b1111, '1));
      send_unit(make_unit(32, 0, 2, 0, 8, 4'b1111, '1));
      send_unit(make_unit(0, 32, 2, 0, 64, 4'b1111, '1));
      send_unit(make_unit(8, 8, 0, 64, 64, 4'b0000, 64'h10004));
      send_unit(make_unit(8, 8, 0, 64, 64, 4'b0000, 64'h0));
      send_unit(make_unit(5, 3, 0, 64, 64, 4'b1111, '1));
      send_unit(make_unit(16, 16, 1, 1904, 1064, 4'b1111, '1));
      send_unit(make_unit(16, 16, 1, 1903, 1063, 4'b1111, '1));
      send_unit(make_unit(0, 8, 0, 0, 0, 4'b0001, '1));
      send_unit(make_unit(8, 0, 0, 0, 0, 4'b0010, '1));
      send_unit(make_unit(24, 40, 0, 4000, 2000, 4'b0100, 64'h5a5a_a5a5_0ff0_f00f));
      send_unit(make_unit(0, 0, 1, 0, 0, 4'b0100, '1));
      send_unit(make_unit(32, 32, 2, 8191, 0, 4'b1111, '1));
      send_unit(make_unit(40, 24, 0, 7, 9, 4'b1010, 64'h0000_0000_0000_0001));

      for (int p = 0; p < 8; p++) begin
         case (p % 4)
            0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
            1: begin sender_idle_pct = 76; receiver_stall_pct = 0; end
            2: begin sender_idle_pct = 0; receiver_stall_pct = 76; end
            default: begin sender_idle_pct = 28; receiver_stall_pct = 28; end
         endcase
         wait_drained();
         case (p)
            0: apply_settings(1920, 1080, 64);
            1: apply_settings(1, 1, 16);
            2: apply_settings(8192, 8192, 64);
            3: apply_settings(8192, 8192, 16);
            4: apply_settings(100, 60, 32);
            6: apply_settings(64, 8192, 48);
            default: apply_settings($urandom_range(1, 8192), $urandom_range(1, 8192),
                                    $urandom_range(16, 64));
         endcase
         run_random_phase(116);
      end

      wait_drained();
      if (sb.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
